// ----- hw/rtl/k_diff_unique_pair_count_top_defines.svh -----
// Assertion macros shared by the k-difference pair counter RTL.
`ifndef K_DIFF_UNIQUE_PAIR_COUNT_TOP_DEFINES_SVH
`define K_DIFF_UNIQUE_PAIR_COUNT_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KDP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KDP_ASSERT_IMPLY(label, ante, cons)
`define KDP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/kdp_pkg.sv -----
// Shared types and constants of the k-difference pair counter.
package kdp_pkg;
  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int FILL_W    = ADDR_W + 1;
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] pair_count;
    logic       overflow;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic grab;
    logic scan;
    logic tally;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
  } dp_status_t;
endpackage

// ----- hw/rtl/k_diff_unique_pair_count_top.sv -----
// Top level of the k-difference unique pair counter.
// Usage: values arrive as beats on the input channel (in_valid, in_stall,
// in_beat), one per cycle while loading. A beat with last set closes the set.
// The block then stalls its input and, for each of the n stored values, reads
// the whole store once through its single memory read port. One result beat
// (pair count and overflow flag) is then offered on the output channel and
// held while out_stall is high; once it is taken the block clears its fill
// count and accepts the next set.
// Up to 1024 values are kept; further values are dropped and flagged. The pair
// distance register is written by the user through cfg_we and cfg_data, only
// while the block is idle, which it does not enforce. Reset empties the store and clears the distance to zero.
module k_diff_unique_pair_count_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  kdp_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output kdp_pkg::out_beat_t out_beat
);
  kdp_pkg::dp_cmd_t    cmd;
  kdp_pkg::dp_status_t status;

  kdp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_beat.last),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  kdp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_beat(in_beat),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .out_beat(out_beat)
  );
endmodule

// ----- hw/rtl/kdp_datapath.sv -----
// Datapath: value store, scan counters, pair comparison and result registers.
`include "k_diff_unique_pair_count_top_defines.svh"
module kdp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  kdp_pkg::dp_cmd_t      cmd,
  output kdp_pkg::dp_status_t   status,
  input  kdp_pkg::in_beat_t     in_beat,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  output kdp_pkg::out_beat_t    out_beat
);
  logic [31:0] store [kdp_pkg::CAPACITY];
  logic [kdp_pkg::FILL_W-1:0] fill_count;
  logic overflow_seen;
  logic [31:0] pair_distance;
  logic [kdp_pkg::ADDR_W-1:0] rd_addr;
  logic [31:0] rd_data;
  logic [kdp_pkg::FILL_W-1:0] i;
  logic [kdp_pkg::FILL_W-1:0] j;
  logic [kdp_pkg::FILL_W-1:0] cmp_j;
  logic [kdp_pkg::FILL_W-1:0] fill_m1;
  logic cmp_valid;
  logic [31:0] x;
  logic [33:0] xk;
  logic dup;
  logic match;
  logic [9:0] count;
  logic has_room;
  logic eq;

  assign has_room = fill_count < kdp_pkg::FILL_W'(kdp_pkg::CAPACITY);
  assign fill_m1  = fill_count - kdp_pkg::FILL_W'(1);
  assign rd_addr  = cmd.fetch ? i[kdp_pkg::ADDR_W-1:0] : j[kdp_pkg::ADDR_W-1:0];
  assign eq       = rd_data == x;
  assign status.j_last = j == fill_m1;
  assign status.i_last = i == fill_m1;
  assign out_beat.pair_count = count;
  assign out_beat.overflow   = overflow_seen;

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      store[fill_count[kdp_pkg::ADDR_W-1:0]] <= in_beat.value;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      pair_distance <= '0;
      cmp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        pair_distance <= cfg_data;
      end
      if (cmd.clear) begin
        fill_count    <= '0;
        overflow_seen <= 1'b0;
      end else if (cmd.load) begin
        if (has_room) begin
          fill_count <= fill_count + kdp_pkg::FILL_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      cmp_valid <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i     <= '0;
      count <= '0;
    end
    if (cmd.grab) begin
      x     <= rd_data;
      xk    <= {{2{rd_data[31]}}, rd_data} + {2'b00, pair_distance};
      j     <= '0;
      dup   <= 1'b0;
      match <= 1'b0;
    end
    if (cmd.scan) begin
      j     <= j + kdp_pkg::FILL_W'(1);
      cmp_j <= j;
    end
    if (cmp_valid) begin
      if (eq && cmp_j < i) begin
        dup <= 1'b1;
      end
      if (pair_distance == 32'd0) begin
        if (eq && cmp_j != i) begin
          match <= 1'b1;
        end
      end else if ({{2{rd_data[31]}}, rd_data} == xk) begin
        match <= 1'b1;
      end
    end
    if (cmd.tally) begin
      i <= i + kdp_pkg::FILL_W'(1);
      if (!dup && match && count != kdp_pkg::COUNT_MAX) begin
        count <= count + 10'd1;
      end
    end
  end

  `KDP_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_count <= kdp_pkg::FILL_W'(kdp_pkg::CAPACITY))
  `KDP_ASSERT_NEXT(a_clear_empties, cmd.clear, fill_count == '0 && !overflow_seen)
  `KDP_ASSERT_IMPLY(a_full_flag, cmd.load && !has_room && !cmd.clear, fill_count != '0)
endmodule

// ----- hw/rtl/kdp_ctrl.sv -----
// Controller: sequences loading, the pairwise scan and result delivery.
`include "k_diff_unique_pair_count_top_defines.svh"
module kdp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  kdp_pkg::dp_status_t  status,
  output kdp_pkg::dp_cmd_t     cmd
);
  typedef enum logic [2:0] {
    S_LOAD, S_FETCH, S_GRAB, S_SCAN, S_DRAIN, S_TALLY, S_OUT
  } state_t;

  state_t state;

  assign in_stall  = state != S_LOAD;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd       = '0;
    cmd.load  = state == S_LOAD && in_valid;
    cmd.fetch = state == S_FETCH;
    cmd.grab  = state == S_GRAB;
    cmd.scan  = state == S_SCAN;
    cmd.tally = state == S_TALLY;
    cmd.clear = state == S_OUT && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid && in_last) state <= S_FETCH;
        end
        S_FETCH: state <= S_GRAB;
        S_GRAB:  state <= S_SCAN;
        S_SCAN: begin
          if (status.j_last) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_TALLY;
        S_TALLY: state <= status.i_last ? S_OUT : S_FETCH;
        S_OUT: begin
          if (!out_stall) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `KDP_ASSERT_IMPLY(a_out_blocks_in, out_valid, in_stall)
  `KDP_ASSERT_NEXT(a_last_starts, in_valid && !in_stall && in_last, in_stall && !out_valid)
  `KDP_ASSERT_NEXT(a_done_returns, out_valid && !out_stall, !in_stall && !out_valid)
endmodule
